// ----- design/mtlu_pkg.sv -----
// Shared constants for the math table lookup unit.
// Request and unit codes, table geometry and section bases.
// No dependencies.
package mtlu_pkg;

	localparam int TABLE_DEPTH = 65536;
	localparam int TABLE_AW    = 16;
	localparam int WORD_W      = 32;

	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	localparam logic [1:0] UNIT_SINCOS = 2'd0;
	localparam logic [1:0] UNIT_ATAN   = 2'd1;
	localparam logic [1:0] UNIT_RECIP  = 2'd2;
	localparam logic [1:0] UNIT_RSQRT  = 2'd3;

	localparam logic [1:0] SEC_SINCOS = 2'b00;
	localparam logic [1:0] SEC_ATAN   = 2'b01;
	localparam logic [1:0] SEC_RECIP  = 2'b10;
	localparam logic [1:0] SEC_RSQRT  = 2'b11;

	localparam logic [7:0] RECIP_BIAS = 8'h7f;
	localparam logic [7:0] RSQRT_BIAS = 8'h3f;

endpackage

// ----- design/math_table_lookup_unit.sv -----
// Math table lookup unit: function table RAM, operand registers and result fixups.
// Depends on mtlu_pkg and mtlu_ram.
// A read result appears with done once the read has passed the valid_s1 and done_q registers.
// Throughput: one transaction per cycle.
// A table load is visible to a read accepted in the following cycle.
// Reset clears the operand registers and the pipeline valid flags; the table is not cleared.
// The receiver cannot stall, so busy never rises.
module math_table_lookup_unit
	import mtlu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [1:0]  unit_sel,
	input  logic [1:0]  port_offset,
	input  logic [31:0] write_value,
	input  logic [31:0] write_mask,
	input  logic [15:0] table_addr,
	output logic        done,
	output logic [31:0] read_data
);

	typedef struct packed {
		logic [1:0] unit;
		logic       port_lsb;
		logic       flip;
		logic [7:0] bias_exp;
		logic       s0;
		logic       s1;
		logic       s2;
	} fix_t;

	function automatic logic [31:0] rebuild_exp(input logic [31:0] w, input logic [7:0] d);
		logic [7:0] e;
		e = w[30:23] + d;
		return {w[31], e, w[22:0]};
	endfunction

	function automatic logic [15:0] atan_fix(input logic [31:0] w, input logic s0,
		input logic s1, input logic s2);
		logic [31:0] r;
		logic [15:0] dt;
		logic [15:0] o;
		r = w;
		dt = w[31:16] + w[15:0];
		if (dt[0]) begin
			r = (r[3:0] == 4'he) ? r - 32'h0000_0001 : r - 32'h0001_0000;
		end
		if (dt[4]) begin
			r = (r[7:4] == 4'he) ? r - 32'h0000_0010 : r - 32'h0010_0000;
		end
		if (dt[8]) begin
			r = (r[11:8] == 4'he) ? r - 32'h0000_0100 : r - 32'h0100_0000;
		end
		o = (s0 ^ s1 ^ s2) ? r[31:16] : r[15:0];
		if (s2) begin
			o = o + 16'h4000;
		end
		if ((s0 && !s2) || (s1 && s2)) begin
			o = o + 16'h8000;
		end
		return o;
	endfunction

	logic [31:0] angle_q;
	logic [31:0] recip_q;
	logic [31:0] rsqrt_q;
	logic [31:0] atan_q [4];

	logic                accept;
	logic                do_load;
	logic                do_write;
	logic                do_read;
	logic [TABLE_AW-1:0] rd_addr;
	fix_t                fix;
	logic [15:0]         ang;
	logic [13:0]         ang_idx;
	logic [13:0]         sc_idx;
	logic [13:0]         at_idx;
	logic [31:0]         ram_rdata;

	logic        valid_s1;
	fix_t        fix_s1;
	logic [31:0] result;
	logic [31:0] read_data_q;
	logic        done_q;

	assign busy     = 1'b0;
	assign accept   = start && !busy;
	assign do_load  = accept && (req_type == REQ_LOAD);
	assign do_write = accept && (req_type == REQ_WRITE);
	assign do_read  = accept && (req_type == REQ_READ);

	assign ang     = angle_q[15:0] + {port_offset, 14'd0};
	assign ang_idx = ang[13:0];
	assign at_idx  = (atan_q[3][15] || atan_q[3][14]) ? 14'h3fff : atan_q[3][13:0];

	always_comb begin
		if (!ang[14]) begin
			sc_idx = ang_idx;
		end else if (ang_idx == 14'd0) begin
			sc_idx = 14'h3fff;
		end else begin
			sc_idx = ~ang_idx + 14'd1;
		end
	end

	always_comb begin
		fix          = '0;
		fix.unit     = unit_sel;
		fix.port_lsb = port_offset[0];
		unique case (unit_sel)
			UNIT_SINCOS: begin
				rd_addr  = {SEC_SINCOS, sc_idx};
				fix.flip = ang[15];
			end
			UNIT_ATAN: begin
				rd_addr = {SEC_ATAN, at_idx};
				fix.s0  = atan_q[0][31];
				fix.s1  = atan_q[1][31];
				fix.s2  = atan_q[2][31];
			end
			UNIT_RECIP: begin
				rd_addr      = {SEC_RECIP, recip_q[22:10], port_offset[0]};
				fix.flip     = recip_q[31];
				fix.bias_exp = RECIP_BIAS - recip_q[30:23];
			end
			UNIT_RSQRT: begin
				rd_addr      = {SEC_RSQRT, ~rsqrt_q[23], rsqrt_q[22:11], port_offset[0]};
				fix.bias_exp = RSQRT_BIAS - {1'b0, rsqrt_q[30:24]};
			end
		endcase
	end

	mtlu_ram #(
		.WIDTH(WORD_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (do_load),
		.waddr(table_addr),
		.wdata(write_value),
		.re   (do_read),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= '0;
			recip_q <= '0;
			rsqrt_q <= '0;
			for (int i = 0; i < 4; i++) begin
				atan_q[i] <= '0;
			end
		end else if (do_write) begin
			unique case (unit_sel)
				UNIT_SINCOS: angle_q <= (angle_q & ~write_mask) | (write_value & write_mask);
				UNIT_ATAN: atan_q[port_offset] <=
					(atan_q[port_offset] & ~write_mask) | (write_value & write_mask);
				UNIT_RECIP: recip_q <= (recip_q & ~write_mask) | (write_value & write_mask);
				UNIT_RSQRT: rsqrt_q <= (rsqrt_q & ~write_mask) | (write_value & write_mask);
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_read) begin
			fix_s1 <= fix;
		end
	end

	always_comb begin
		unique case (fix_s1.unit)
			UNIT_SINCOS: result = ram_rdata ^ {fix_s1.flip, 31'd0};
			UNIT_ATAN: result = {16'd0, atan_fix(ram_rdata, fix_s1.s0, fix_s1.s1, fix_s1.s2)};
			UNIT_RECIP: result = rebuild_exp(ram_rdata, fix_s1.bias_exp) ^ {fix_s1.flip, 31'd0};
			UNIT_RSQRT: begin
				result = rebuild_exp(ram_rdata, fix_s1.bias_exp);
				if (!fix_s1.port_lsb) begin
					result[31] = 1'b0;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			read_data_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= do_read;
			done_q   <= valid_s1;
		end
	end

	assign done      = done_q;
	assign read_data = read_data_q;

	a_read_enters_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req_type == REQ_READ) |=> valid_s1)
		else $error("accepted read transaction did not enter the pipeline");

	a_nonread_no_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy && (req_type == REQ_READ)) |=> !valid_s1)
		else $error("pipeline started without a read transaction");

	a_read_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("read transaction lost before the result strobe");

	a_no_spurious_done: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |=> !done)
		else $error("result strobe without a read transaction");

endmodule

// ----- design/mtlu_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// Width and depth are parameters; no reset on the storage.
// No dependencies.
module mtlu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- test/tb_top.sv -----
// Testbench for math_table_lookup_unit: table loads, masked operand writes and result reads.
// A scoreboard class predicts every read result and checks it against the done strobe.
// Depends on mtlu_pkg and the math_table_lookup_unit RTL.
`timescale 1ns / 1ps

class lookup_scoreboard;
	logic [31:0] fn_words [mtlu_pkg::TABLE_DEPTH];
	bit          written [mtlu_pkg::TABLE_DEPTH];
	logic [31:0] angle_op;
	logic [31:0] recip_op;
	logic [31:0] rsqrt_op;
	logic [31:0] atan_ops [4];
	logic [31:0] expected_words [$];
	int          errors;
	int          loads_seen;
	int          writes_seen;
	int          reads_seen;
	int          ignored_seen;

	function new();
		angle_op = '0;
		recip_op = '0;
		rsqrt_op = '0;
		foreach (atan_ops[i]) atan_ops[i] = '0;
		errors = 0;
		loads_seen = 0;
		writes_seen = 0;
		reads_seen = 0;
		ignored_seen = 0;
	endfunction

	function int pending();
		return expected_words.size();
	endfunction

	function logic [15:0] entry_for(logic [1:0] unit, logic [1:0] port);
		logic [31:0] ang;
		logic [15:0] idx;
		case (unit)
			mtlu_pkg::UNIT_SINCOS: begin
				ang = angle_op + {16'h0, port, 14'h0};
				idx = {2'b00, ang[13:0]};
				if (ang[14]) begin
					idx = 16'h4000 - idx;
					if (idx > 16'h3fff) idx = 16'h3fff;
				end
			end
			mtlu_pkg::UNIT_ATAN: begin
				idx = atan_ops[3][15:0];
				if (idx[15] || idx[14]) idx = 16'h3fff;
				idx = idx | 16'h4000;
			end
			mtlu_pkg::UNIT_RECIP: idx = {2'b10, recip_op[22:10], port[0]};
			default: idx = {2'b11, ~rsqrt_op[23], rsqrt_op[22:11], port[0]};
		endcase
		return idx;
	endfunction

	function logic [31:0] predict_read(logic [1:0] unit, logic [1:0] port);
		logic [31:0] w;
		logic [31:0] ang;
		logic [15:0] dt;
		logic        s0, s1, s2;
		w = fn_words[entry_for(unit, port)];
		case (unit)
			mtlu_pkg::UNIT_SINCOS: begin
				ang = angle_op + {16'h0, port, 14'h0};
				if (ang[15]) w[31] = ~w[31];
			end
			mtlu_pkg::UNIT_ATAN: begin
				dt = w[31:16] + w[15:0];
				if (dt[0]) begin
					if (w[3:0] == 4'he) w = w - 32'h0000_0001;
					else w = w - 32'h0001_0000;
				end
				if (dt[4]) begin
					if (w[7:4] == 4'he) w = w - 32'h0000_0010;
					else w = w - 32'h0010_0000;
				end
				if (dt[8]) begin
					if (w[11:8] == 4'he) w = w - 32'h0000_0100;
					else w = w - 32'h0100_0000;
				end
				s0 = atan_ops[0][31];
				s1 = atan_ops[1][31];
				s2 = atan_ops[2][31];
				if (s0 ^ s1 ^ s2) w = w >> 16;
				if (s2) w = w + 32'h4000;
				if ((s0 && !s2) || (s1 && s2)) w = w + 32'h8000;
				w = {16'h0, w[15:0]};
			end
			mtlu_pkg::UNIT_RECIP: begin
				w[30:23] = w[30:23] + mtlu_pkg::RECIP_BIAS - recip_op[30:23];
				if (recip_op[31]) w[31] = ~w[31];
			end
			default: begin
				w[30:23] = w[30:23] + mtlu_pkg::RSQRT_BIAS - {1'b0, rsqrt_op[30:24]};
				if (!port[0]) w[31] = 1'b0;
			end
		endcase
		return w;
	endfunction

	function void note_input(logic [1:0] req, logic [1:0] unit, logic [1:0] port,
			logic [31:0] val, logic [31:0] mask, logic [15:0] addr);
		case (req)
			mtlu_pkg::REQ_LOAD: begin
				fn_words[addr] = val;
				written[addr] = 1'b1;
				loads_seen++;
			end
			mtlu_pkg::REQ_WRITE: begin
				writes_seen++;
				case (unit)
					mtlu_pkg::UNIT_SINCOS: angle_op = (angle_op & ~mask) | (val & mask);
					mtlu_pkg::UNIT_ATAN:
						atan_ops[port] = (atan_ops[port] & ~mask) | (val & mask);
					mtlu_pkg::UNIT_RECIP: recip_op = (recip_op & ~mask) | (val & mask);
					default: rsqrt_op = (rsqrt_op & ~mask) | (val & mask);
				endcase
			end
			mtlu_pkg::REQ_READ: begin
				reads_seen++;
				expected_words.push_back(predict_read(unit, port));
			end
			default: ignored_seen++;
		endcase
	endfunction

	function void check_result(logic [31:0] got);
		logic [31:0] want;
		if (expected_words.size() == 0) begin
			errors++;
			$display("%0t: read_data expected none, actual %h", $time, got);
			return;
		end
		want = expected_words.pop_front();
		if (got !== want) begin
			errors++;
			$display("%0t: read_data expected %h, actual %h", $time, want, got);
		end
	endfunction
endclass

module tb_top
	import mtlu_pkg::*;
();

	localparam logic [1:0] REQ_NONE = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  req_type;
	logic [1:0]  unit_sel;
	logic [1:0]  port_offset;
	logic [31:0] write_value;
	logic [31:0] write_mask;
	logic [15:0] table_addr;
	logic        done;
	logic [31:0] read_data;

	lookup_scoreboard sb = new();
	int gap_pct;
	int items_sent;

	math_table_lookup_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.unit_sel(unit_sel),
		.port_offset(port_offset),
		.write_value(write_value),
		.write_mask(write_mask),
		.table_addr(table_addr),
		.done(done),
		.read_data(read_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (done === 1'b1) sb.check_result(read_data);
	end

	initial begin
		#5ms;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic send(input logic [1:0] rq, input logic [1:0] un, input logic [1:0] po,
			input logic [31:0] val, input logic [31:0] msk, input logic [15:0] adr);
		req_type <= rq;
		unit_sel <= un;
		port_offset <= po;
		write_value <= val;
		write_mask <= msk;
		table_addr <= adr;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_input(rq, un, po, val, msk, adr);
		if (rq != REQ_NONE) items_sent++;
		@(negedge clk);
		if ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			req_type <= 2'($urandom);
			write_value <= $urandom;
			table_addr <= 16'($urandom);
			do @(negedge clk); while ($urandom_range(99) < gap_pct);
		end
	endtask

	// A read is preceded by a load whenever reload is set or the entry it uses holds nothing yet.
	task automatic read_entry(input logic [1:0] un, input logic [1:0] po,
			input logic [31:0] word, input bit reload);
		logic [15:0] adr;
		adr = sb.entry_for(un, po);
		if (reload || !sb.written[adr])
			send(REQ_LOAD, 2'($urandom), 2'($urandom), word, $urandom, adr);
		send(REQ_READ, un, po, $urandom, $urandom, 16'($urandom));
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [31:0] table_word();
		logic [31:0] w;
		w = $urandom;
		if ($urandom_range(2) == 0) w[3:0] = 4'he;
		if ($urandom_range(2) == 0) w[7:4] = 4'he;
		if ($urandom_range(2) == 0) w[11:8] = 4'he;
		if ($urandom_range(5) == 0) w[30:23] = $urandom_range(1) ? 8'hff : 8'h00;
		return w;
	endfunction

	task automatic random_item();
		int          pick;
		int          mode;
		logic [1:0]  un;
		logic [1:0]  po;
		logic [31:0] val;
		logic [31:0] msk;
		pick = $urandom_range(99);
		un = 2'($urandom);
		po = 2'($urandom);
		if (pick < 20) begin
			send(REQ_LOAD, un, po, table_word(), $urandom, 16'($urandom));
		end else if (pick < 50) begin
			val = $urandom;
			mode = $urandom_range(19);
			if (mode < 10) msk = '1;
			else if (mode < 17) msk = $urandom;
			else if (mode < 18) msk = '0;
			else msk = 32'hff << (8 * $urandom_range(3));
			if ($urandom_range(7) == 0) val[30:23] = $urandom_range(1) ? 8'hff : 8'h00;
			if (un == UNIT_ATAN && po == 2'd3 && $urandom_range(3) != 0) val[15:14] = 2'b00;
			send(REQ_WRITE, un, po, val, msk, 16'($urandom));
		end else if (pick < 95) begin
			read_entry(un, po, table_word(), $urandom_range(3) == 0);
		end else begin
			send(REQ_NONE, un, po, $urandom, $urandom, 16'($urandom));
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		req_type = REQ_LOAD;
		unit_sel = UNIT_SINCOS;
		port_offset = 2'd0;
		write_value = '0;
		write_mask = '0;
		table_addr = '0;
		items_sent = 0;
		gap_pct = 12;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send(REQ_LOAD, UNIT_SINCOS, 2'd0, 32'h1357_9bdf, 32'h0, 16'h0000);
		send(REQ_LOAD, UNIT_SINCOS, 2'd0, 32'h7fff_ffff, 32'h0, 16'h3fff);
		for (int p = 0; p < 4; p++)
			send(REQ_READ, UNIT_SINCOS, 2'(p), $urandom, $urandom, 16'($urandom));
		send(REQ_NONE, UNIT_RECIP, 2'd3, '1, '1, 16'hffff);
		send(REQ_WRITE, UNIT_SINCOS, 2'd3, 32'hffff_ffff, 32'hffff_ffff, 16'h0);
		read_entry(UNIT_SINCOS, 2'd1, 32'h8000_0000, 1'b1);
		send(REQ_WRITE, UNIT_ATAN, 2'd3, 32'h0000_c000, 32'hffff_ffff, 16'h0);
		send(REQ_WRITE, UNIT_ATAN, 2'd0, 32'hffff_ffff, 32'h8000_0000, 16'h0);
		read_entry(UNIT_ATAN, 2'd2, 32'heeee_eeee, 1'b1);
		send(REQ_WRITE, UNIT_ATAN, 2'd2, 32'h8000_0000, 32'h8000_0000, 16'h0);
		send(REQ_WRITE, UNIT_ATAN, 2'd1, 32'h8000_0000, 32'h8000_0000, 16'h0);
		send(REQ_READ, UNIT_ATAN, 2'd0, $urandom, $urandom, 16'($urandom));
		send(REQ_WRITE, UNIT_RECIP, 2'd2, 32'h8055_5555, 32'hffff_ffff, 16'h0);
		read_entry(UNIT_RECIP, 2'd3, 32'h7f80_0001, 1'b1);
		send(REQ_WRITE, UNIT_RSQRT, 2'd1, 32'h7fff_ffff, 32'hffff_ffff, 16'h0);
		read_entry(UNIT_RSQRT, 2'd2, 32'h8000_0000, 1'b1);
		read_entry(UNIT_RSQRT, 2'd1, 32'hffff_ffff, 1'b1);
		drain();

		while (items_sent < 725) random_item();
		drain();
		gap_pct = 59;
		while (items_sent < 1425) random_item();
		drain();
		gap_pct = 0;
		while (items_sent < 2025) random_item();
		drain();

		$display("Covered %0d table loads, %0d operand writes, %0d checked reads, %0d ignored.",
			sb.loads_seen, sb.writes_seen, sb.reads_seen, sb.ignored_seen);
		$display("Senders gaps of 12 and 59 percent and back-to-back traffic; %0d mismatches.",
			sb.errors);
		if (sb.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

// ----- sim.f -----
design/mtlu_pkg.sv
design/mtlu_ram.sv
design/math_table_lookup_unit.sv
test/tb_top.sv
